// ----- hdl/bidl_pkg.sv -----
// bidl_pkg: shared widths, codes and controller/datapath structs for the bounded id list engine
// no dependencies; compiled first

package bidl_pkg;

   localparam int ID_W         = 16;
   localparam int OP_W         = 3;
   localparam int LIST_SEL_W   = 2;
   localparam int SLOT_W       = 5;
   localparam int COUNT_W      = 6;
   localparam int CAP_W        = 6;
   localparam int NUM_CAP_REGS = 3;
   localparam int CSR_IDX_W    = 2;

   localparam int NUM_LISTS_DEF    = 3;
   localparam int MAX_CAPACITY_DEF = 32;

   localparam logic [ID_W-1:0]  EMPTY_ID  = 16'hFFFF;
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

   typedef enum logic [OP_W-1:0] {
      OP_ADD,
      OP_ADD_UNIQUE,
      OP_REMOVE_FIRST,
      OP_REMOVE_ALL,
      OP_CLEAR,
      OP_CONTAINS,
      OP_READ_SLOT,
      OP_COUNT
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAP_A,
      CSR_CAP_B,
      CSR_CAP_C
   } csr_index_type;

   typedef enum logic {
      MODE_SCAN,
      MODE_SHIFT
   } pass_mode_type;

   typedef struct packed {
      logic          init_run;
      logic          load;
      logic          pass_run;
      logic          pass_restart;
      pass_mode_type mode;
      logic          fill_run;
      logic          out_load;
   } cmd_type;

   typedef struct packed {
      logic init_done;
      logic pass_done;
      logic fill_done;
      logic need_shift;
      logic need_fill;
      logic out_free;
   } status_type;

endpackage

// ----- hdl/bidl_channels.sv -----
// bidl_req_if and bidl_rsp_if: valid/ready channels for requests and results
// depends on bidl_pkg

interface bidl_req_if import bidl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   op_type                 op;
   logic [LIST_SEL_W-1:0]  list_sel;
   logic signed [ID_W-1:0] item_id;
   logic [SLOT_W-1:0]      slot;

   modport source (output valid, output op, output list_sel, output item_id, output slot,
                   input ready);
   modport sink (input valid, input op, input list_sel, input item_id, input slot,
                 output ready);
endinterface

interface bidl_rsp_if import bidl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [COUNT_W-1:0]     removed_count;
   logic signed [ID_W-1:0] slot_value;
   logic [COUNT_W-1:0]     item_count;

   modport source (output valid, output ok, output removed_count, output slot_value,
                   output item_count, input ready);
   modport sink (input valid, input ok, input removed_count, input slot_value,
                 input item_count, output ready);
endinterface

// ----- hdl/bounded_id_list_engine_unit.sv -----
// Bounded id list engine: several lists of 16-bit ids in one slot memory, one slot per cycle.
// Every pass walks the list through the single read and single write port of the slot
// memory; a successful add is followed by a shift pass and a remove by a fill pass. One
// request is worked at a time; the next one is taken while the previous result still waits
// in the output register. After reset a clearing pass empties the memory, and no request
// is taken until it ends (capacity writes are taken).
// Depends on bidl_pkg, bidl_channels, bidl_ctrl and bidl_dpath.

module bounded_id_list_engine_unit import bidl_pkg::*; #(
   parameter int NUM_LISTS    = NUM_LISTS_DEF,
   parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   bidl_req_if.sink             req_bus,
   bidl_rsp_if.source           rsp_bus,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAP_W-1:0]     csr_write_data
);

   cmd_type    cmd;
   status_type status;

   bidl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bidl_dpath #(
      .NUM_LISTS    (NUM_LISTS),
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_op            (req_bus.op),
      .req_list_sel      (req_bus.list_sel),
      .req_item_id       (req_bus.item_id),
      .req_slot          (req_bus.slot),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ok            (rsp_bus.ok),
      .rsp_removed_count (rsp_bus.removed_count),
      .rsp_slot_value    (rsp_bus.slot_value),
      .rsp_item_count    (rsp_bus.item_count)
   );

endmodule

// ----- hdl/bidl_dpath.sv -----
// bidl_dpath: slot memory, capacity registers, scan/shift/fill counters and result register
// depends on bidl_pkg; driven by bidl_ctrl through cmd_type / status_type

module bidl_dpath import bidl_pkg::*; #(
   parameter int NUM_LISTS    = NUM_LISTS_DEF,
   parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CAP_W-1:0]       csr_write_data,
   input  op_type                 req_op,
   input  logic [LIST_SEL_W-1:0]  req_list_sel,
   input  logic signed [ID_W-1:0] req_item_id,
   input  logic [SLOT_W-1:0]      req_slot,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_ok,
   output logic [COUNT_W-1:0]     rsp_removed_count,
   output logic signed [ID_W-1:0] rsp_slot_value,
   output logic [COUNT_W-1:0]     rsp_item_count
);

   localparam int DEPTH  = NUM_LISTS * MAX_CAPACITY;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(MAX_CAPACITY + 1);
   localparam int INIT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0]  CAP_MAX   = CNT_W'(MAX_CAPACITY);
   localparam logic [INIT_W-1:0] INIT_LAST = INIT_W'(DEPTH);

   logic [ID_W-1:0]   mem [DEPTH];
   logic [CAP_W-1:0]  cap_reg_ff [NUM_CAP_REGS];

   op_type            op_ff;
   logic              bad_ff;
   logic [ID_W-1:0]   id_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [CNT_W-1:0]  cap_sel_ff;
   logic [CNT_W-1:0]  rd_idx_ff;
   logic [CNT_W-1:0]  pidx_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [CNT_W-1:0]  removed_ff;
   logic [CNT_W-1:0]  w_ff;
   logic              pv_ff;
   logic              seen_empty_ff;
   logic              found_ff;
   logic [ID_W-1:0]   rd_data_ff;
   logic [ID_W-1:0]   value_ff;
   logic [ID_W-1:0]   carry_ff;
   logic [INIT_W-1:0] init_ctr_ff;

   logic              out_vld_ff;
   logic              out_ok_ff;
   logic [CNT_W-1:0]  out_removed_ff;
   logic [ID_W-1:0]   out_value_ff;
   logic [CNT_W-1:0]  out_count_ff;

   logic [CAP_W-1:0]  cap_raw;
   logic              req_bad;
   logic [CNT_W-1:0]  load_cap;

   logic              in_prefix;
   logic              hit;
   logic              is_remove;
   logic              skip;
   logic              rd_go;
   logic [ADDR_W-1:0] rd_addr;

   logic              mem_we;
   logic [CNT_W-1:0]  wr_idx;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ID_W-1:0]   mem_wdata;

   logic              add_ok;
   logic              res_ok;
   logic [CNT_W-1:0]  res_removed;
   logic [ID_W-1:0]   res_value;
   logic [CNT_W-1:0]  res_count;

   // capacity of the requested list, clamped
   always_comb begin
      unique case (req_list_sel)
         2'd0:    cap_raw = cap_reg_ff[0];
         2'd1:    cap_raw = cap_reg_ff[1];
         2'd2:    cap_raw = cap_reg_ff[2];
         default: cap_raw = '0;
      endcase
      req_bad  = 32'(req_list_sel) >= NUM_LISTS;
      load_cap = (32'(cap_raw) > MAX_CAPACITY) ? CAP_MAX : CNT_W'(cap_raw);
      if (req_bad) begin
         load_cap = '0;
      end
   end

   // per-slot decisions on the data returned by the read port
   always_comb begin
      in_prefix = !seen_empty_ff && (rd_data_ff != EMPTY_ID);
      hit       = in_prefix && (rd_data_ff == id_ff);
      is_remove = (op_ff == OP_REMOVE_FIRST) || (op_ff == OP_REMOVE_ALL);
      skip      = is_remove && hit && ((op_ff == OP_REMOVE_ALL) || !found_ff);
      rd_go     = cmd.pass_run && !cmd.pass_restart && (rd_idx_ff != cap_sel_ff);
      rd_addr   = base_ff + ADDR_W'(rd_idx_ff);
   end

   // write port selection
   always_comb begin
      mem_we    = 1'b0;
      wr_idx    = '0;
      mem_wdata = EMPTY_ID;
      if (cmd.init_run) begin
         mem_we = init_ctr_ff != INIT_LAST;
      end else if (cmd.fill_run) begin
         mem_we = w_ff != cap_sel_ff;
         wr_idx = w_ff;
      end else if (pv_ff && cmd.mode == MODE_SHIFT) begin
         mem_we    = 1'b1;
         wr_idx    = pidx_ff;
         mem_wdata = carry_ff;
      end else if (pv_ff && is_remove) begin
         mem_we    = !skip;
         wr_idx    = w_ff;
         mem_wdata = rd_data_ff;
      end else if (pv_ff && op_ff == OP_CLEAR) begin
         mem_we = 1'b1;
         wr_idx = pidx_ff;
      end else begin
         mem_we = 1'b0;
      end
      mem_waddr = cmd.init_run ? ADDR_W'(init_ctr_ff) : base_ff + ADDR_W'(wr_idx);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_go) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // result of the finished operation
   always_comb begin
      add_ok      = (n_ff != cap_sel_ff) && !((op_ff == OP_ADD_UNIQUE) && found_ff);
      res_ok      = 1'b0;
      res_removed = '0;
      res_value   = EMPTY_ID;
      res_count   = n_ff;
      if (bad_ff) begin
         res_count = '0;
      end else begin
         unique case (op_ff)
            OP_ADD, OP_ADD_UNIQUE: begin
               res_ok = add_ok;
               if (add_ok) begin
                  res_count = (id_ff == EMPTY_ID) ? '0 : n_ff + 1'b1;
               end
            end
            OP_REMOVE_FIRST, OP_REMOVE_ALL: begin
               res_ok      = removed_ff != '0;
               res_removed = removed_ff;
               res_count   = n_ff - removed_ff;
            end
            OP_CLEAR: begin
               res_ok      = 1'b1;
               res_removed = n_ff;
               res_count   = '0;
            end
            OP_CONTAINS: begin
               res_ok = found_ff;
            end
            OP_READ_SLOT: begin
               if (32'(slot_ff) < 32'(cap_sel_ff)) begin
                  res_ok    = 1'b1;
                  res_value = value_ff;
               end
            end
            OP_COUNT: begin
               res_ok = 1'b1;
            end
            default: begin
               res_ok = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_reg_ff[0] <= CAP_RESET;
         cap_reg_ff[1] <= CAP_RESET;
         cap_reg_ff[2] <= CAP_RESET;
         init_ctr_ff   <= '0;
         out_vld_ff    <= 1'b0;
         cap_sel_ff    <= '0;
         rd_idx_ff     <= '0;
         pv_ff         <= 1'b0;
         n_ff          <= '0;
         removed_ff    <= '0;
         w_ff          <= '0;
         seen_empty_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_CAP_A: cap_reg_ff[0] <= csr_write_data;
               CSR_CAP_B: cap_reg_ff[1] <= csr_write_data;
               CSR_CAP_C: cap_reg_ff[2] <= csr_write_data;
               default:   cap_reg_ff[0] <= cap_reg_ff[0];
            endcase
         end
         if (cmd.init_run && init_ctr_ff != INIT_LAST) begin
            init_ctr_ff <= init_ctr_ff + 1'b1;
         end
         if (cmd.out_load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
         if (cmd.load) begin
            cap_sel_ff    <= load_cap;
            rd_idx_ff     <= '0;
            pv_ff         <= 1'b0;
            n_ff          <= '0;
            removed_ff    <= '0;
            w_ff          <= '0;
            seen_empty_ff <= 1'b0;
            found_ff      <= 1'b0;
         end else if (cmd.pass_restart) begin
            rd_idx_ff <= '0;
            pv_ff     <= 1'b0;
         end else begin
            pv_ff <= rd_go;
            if (rd_go) begin
               rd_idx_ff <= rd_idx_ff + 1'b1;
            end
            if (pv_ff && cmd.mode == MODE_SCAN) begin
               if (!in_prefix) begin
                  seen_empty_ff <= 1'b1;
               end else begin
                  n_ff <= n_ff + 1'b1;
               end
               if (hit) begin
                  found_ff <= 1'b1;
               end
               if (skip) begin
                  removed_ff <= removed_ff + 1'b1;
               end else if (is_remove) begin
                  w_ff <= w_ff + 1'b1;
               end
            end
            if (cmd.fill_run && w_ff != cap_sel_ff) begin
               w_ff <= w_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         bad_ff   <= req_bad;
         id_ff    <= req_item_id;
         slot_ff  <= req_slot;
         base_ff  <= ADDR_W'(32'(req_list_sel) * MAX_CAPACITY);
         value_ff <= EMPTY_ID;
      end else if (pv_ff && cmd.mode == MODE_SCAN && 32'(pidx_ff) == 32'(slot_ff)) begin
         value_ff <= rd_data_ff;
      end
      if (rd_go) begin
         pidx_ff <= rd_idx_ff;
      end
      if (cmd.pass_restart) begin
         carry_ff <= id_ff;
      end else if (pv_ff && cmd.mode == MODE_SHIFT) begin
         carry_ff <= rd_data_ff;
      end
      if (cmd.out_load) begin
         out_ok_ff      <= res_ok;
         out_removed_ff <= res_removed;
         out_value_ff   <= res_value;
         out_count_ff   <= res_count;
      end
   end

   always_comb begin
      status.init_done  = init_ctr_ff == INIT_LAST;
      status.pass_done  = (rd_idx_ff == cap_sel_ff) && !pv_ff;
      status.fill_done  = w_ff == cap_sel_ff;
      status.need_shift = ((op_ff == OP_ADD) || (op_ff == OP_ADD_UNIQUE)) && add_ok && !bad_ff;
      status.need_fill  = is_remove;
      status.out_free   = !out_vld_ff || rsp_ready;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_ok            = out_ok_ff;
   assign rsp_removed_count = COUNT_W'(out_removed_ff);
   assign rsp_slot_value    = out_value_ff;
   assign rsp_item_count    = COUNT_W'(out_count_ff);

   a_compact_behind_scan: assert property (@(posedge clock) disable iff (reset)
      (pv_ff && cmd.mode == MODE_SCAN) |-> (w_ff <= pidx_ff))
      else $error("compaction write pointer ran ahead of scan");

   a_write_within_list: assert property (@(posedge clock) disable iff (reset)
      (mem_we && !cmd.init_run) |-> (wr_idx < cap_sel_ff))
      else $error("slot write beyond list capacity");

   a_removed_le_count: assert property (@(posedge clock) disable iff (reset)
      removed_ff <= n_ff)
      else $error("removed more entries than were counted");

endmodule

// ----- hdl/bidl_ctrl.sv -----
// bidl_ctrl: sequencer for memory clearing, scan, shift, fill and result transfer
// depends on bidl_pkg; commands bidl_dpath through cmd_type / status_type

module bidl_ctrl import bidl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FILL,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd          = '0;
      cmd.mode     = MODE_SCAN;
      state_in     = state_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_run = 1'b1;
            if (status.init_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.pass_run = 1'b1;
            if (status.pass_done) begin
               priority if (status.need_shift) begin
                  cmd.pass_restart = 1'b1;
                  state_in         = ST_SHIFT;
               end else if (status.need_fill) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SHIFT: begin
            cmd.pass_run = 1'b1;
            cmd.mode     = MODE_SHIFT;
            if (status.pass_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FILL: begin
            cmd.fill_run = 1'b1;
            if (status.fill_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_starts_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a scan");

   a_shift_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> $past(state_ff == ST_SCAN || state_ff == ST_SHIFT))
      else $error("shift pass entered without a scan");

   a_result_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (state_ff == ST_IDLE))
      else $error("result transfer did not return to idle");

endmodule

// ----- tb/tb_bounded_id_list_engine_unit.sv -----
// tb_bounded_id_list_engine_unit: self-checking bench for the bounded id list engine
// uses bidl_pkg, bidl_channels and bounded_id_list_engine_unit; a shadow copy of the
// lists predicts every result, which is checked field by field in transfer order

`timescale 1ns / 1ps

module tb_bounded_id_list_engine_unit;
   import bidl_pkg::*;

   localparam int                   RANDOM_ITEMS       = 1830;
   localparam int                   LIST_SETTLE_CYCLES = 80;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX   = 2'd3;
   localparam logic [LIST_SEL_W-1:0] BAD_LIST          = 2'd3;

   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] removed_count;
      logic [ID_W-1:0]    slot_value;
      logic [COUNT_W-1:0] item_count;
   } list_answer_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CAP_W-1:0]     csr_write_data;

   bidl_req_if req_bus ();
   bidl_rsp_if rsp_bus ();

   bounded_id_list_engine_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   logic [ID_W-1:0]  slot_mem [NUM_LISTS_DEF][MAX_CAPACITY_DEF];
   logic [CAP_W-1:0] cap_shadow [NUM_CAP_REGS];
   logic [ID_W-1:0]  id_pool [6];
   list_answer_type  awaited_answers [$];
   int               fault_count = 0;
   int unsigned      burst_left = 0;
   bit               req_live = 1'b0;
   int unsigned      stall_tick = 0;
   int unsigned      stall_mode = 0;
   int unsigned      stall_hold = 0;
   bit               ready_level = 1'b1;

   always #4 clock = ~clock;

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // shadow of the list store

   function automatic int unsigned live_cap(input int unsigned l);
      return (cap_shadow[l] > MAX_CAPACITY_DEF) ? MAX_CAPACITY_DEF : cap_shadow[l];
   endfunction

   function automatic int unsigned live_count(input int unsigned l);
      int unsigned c;
      int unsigned n;
      c = live_cap(l);
      n = 0;
      while (n < c && slot_mem[l][n] != EMPTY_ID) n++;
      return n;
   endfunction

   function automatic int find_id(input int unsigned l, input logic [ID_W-1:0] id);
      int unsigned n;
      int unsigned i;
      n = live_count(l);
      for (i = 0; i < n; i++) begin
         if (slot_mem[l][i] == id) return i;
      end
      return -1;
   endfunction

   function automatic bit drop_first(input int unsigned l, input logic [ID_W-1:0] id);
      int          k;
      int unsigned c;
      int unsigned i;
      k = find_id(l, id);
      if (k < 0) return 1'b0;
      c = live_cap(l);
      for (i = k; i + 1 < c; i++) slot_mem[l][i] = slot_mem[l][i+1];
      if (c > 0) slot_mem[l][c-1] = EMPTY_ID;
      return 1'b1;
   endfunction

   function automatic list_answer_type predict_list_op(input op_type op,
                                                       input logic [LIST_SEL_W-1:0] sel,
                                                       input logic [ID_W-1:0] id,
                                                       input logic [SLOT_W-1:0] slot);
      list_answer_type ans;
      int unsigned     l;
      int unsigned     c;
      int unsigned     n;
      int unsigned     i;
      ans.ok            = 1'b0;
      ans.removed_count = '0;
      ans.slot_value    = EMPTY_ID;
      ans.item_count    = '0;
      l = 32'(sel);
      if (l < NUM_LISTS_DEF) begin
         c = live_cap(l);
         case (op)
            OP_ADD, OP_ADD_UNIQUE: begin
               if (!(op == OP_ADD_UNIQUE && find_id(l, id) >= 0) && live_count(l) < c) begin
                  for (i = c - 1; i > 0; i--) slot_mem[l][i] = slot_mem[l][i-1];
                  slot_mem[l][0] = id;
                  ans.ok = 1'b1;
               end
            end
            OP_REMOVE_FIRST: begin
               if (drop_first(l, id)) begin
                  ans.ok            = 1'b1;
                  ans.removed_count = COUNT_W'(1);
               end
            end
            OP_REMOVE_ALL: begin
               n = 0;
               while (n < MAX_CAPACITY_DEF && drop_first(l, id)) n++;
               ans.ok            = (n > 0);
               ans.removed_count = COUNT_W'(n);
            end
            OP_CLEAR: begin
               ans.removed_count = COUNT_W'(live_count(l));
               for (i = 0; i < c; i++) slot_mem[l][i] = EMPTY_ID;
               ans.ok = 1'b1;
            end
            OP_CONTAINS: begin
               ans.ok = (find_id(l, id) >= 0);
            end
            OP_READ_SLOT: begin
               if (slot < c) begin
                  ans.slot_value = slot_mem[l][slot];
                  ans.ok         = 1'b1;
               end
            end
            default: begin
               ans.ok = 1'b1;
            end
         endcase
         ans.item_count = COUNT_W'(live_count(l));
      end
      return ans;
   endfunction

   // stimulus helpers

   task automatic issue_request(input op_type op, input logic [LIST_SEL_W-1:0] sel,
                                input logic [ID_W-1:0] id, input logic [SLOT_W-1:0] slot);
      int unsigned gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0)
            gap = 0;
         else if ($urandom_range(0, 7) == 0)
            gap = $urandom_range(20, 80);
         else
            gap = $urandom_range(1, 10);
         if (gap > 0 && req_live) begin
            req_bus.valid <= 1'b0;
            req_live = 1'b0;
         end
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_bus.valid    <= 1'b1;
      req_bus.op       <= op;
      req_bus.list_sel <= sel;
      req_bus.item_id  <= id;
      req_bus.slot     <= slot;
      req_live = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      awaited_answers.insert(awaited_answers.size(), predict_list_op(op, sel, id, slot));
   endtask

   task automatic wait_for_idle();
      if (req_live) begin
         req_bus.valid <= 1'b0;
         req_live = 1'b0;
      end
      burst_left = 0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (LIST_SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CSR_IDX_W-1:0] idx, input logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx < NUM_CAP_REGS) cap_shadow[idx] = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [CAP_W-1:0] pick_capacity();
      case ($urandom_range(0, 9))
         0:       return CAP_W'(0);
         1:       return CAP_W'(32);
         2:       return CAP_W'($urandom_range(33, 63));
         8:       return CAP_W'($urandom_range(7, 31));
         9:       return CAP_W'(63);
         default: return CAP_W'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic op_type pick_op();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 28) return OP_ADD;
      if (r < 42) return OP_ADD_UNIQUE;
      if (r < 54) return OP_REMOVE_FIRST;
      if (r < 62) return OP_REMOVE_ALL;
      if (r < 66) return OP_CLEAR;
      if (r < 78) return OP_CONTAINS;
      if (r < 92) return OP_READ_SLOT;
      return OP_COUNT;
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return id_pool[$urandom_range(0, 5)];
      if (r < 74) return EMPTY_ID;
      if (r < 78) return 16'h8000;
      if (r < 82) return 16'h7FFF;
      if (r < 85) return 16'h0000;
      return ID_W'($urandom);
   endfunction

   // tests

   task automatic test_empty_lists();
      issue_request(OP_COUNT, 2'd0, 16'h1234, 5'd0);
      issue_request(OP_READ_SLOT, 2'd2, 16'h0000, 5'd31);
   endtask

   task automatic test_add_and_search();
      issue_request(OP_ADD, 2'd0, 16'h7FFF, 5'd0);
      issue_request(OP_ADD, 2'd0, 16'h8000, 5'd0);
      issue_request(OP_ADD_UNIQUE, 2'd0, 16'h7FFF, 5'd0);
      issue_request(OP_ADD, 2'd0, 16'h7FFF, 5'd0);
      issue_request(OP_CONTAINS, 2'd0, 16'h8000, 5'd0);
      issue_request(OP_CONTAINS, 2'd0, 16'h0000, 5'd0);
   endtask

   task automatic test_removal();
      issue_request(OP_REMOVE_ALL, 2'd0, 16'h7FFF, 5'd0);
      issue_request(OP_REMOVE_FIRST, 2'd0, 16'h8000, 5'd0);
      issue_request(OP_REMOVE_FIRST, 2'd0, 16'h8000, 5'd0);
      issue_request(OP_ADD, 2'd1, 16'h0000, 5'd0);
      // an empty marker pushed to the front hides the whole list
      issue_request(OP_ADD, 2'd1, EMPTY_ID, 5'd0);
      issue_request(OP_CLEAR, 2'd1, 16'h0000, 5'd0);
   endtask

   task automatic test_bad_list();
      issue_request(OP_ADD, BAD_LIST, 16'h0042, 5'd0);
      issue_request(OP_CLEAR, BAD_LIST, 16'h0000, 5'd0);
      issue_request(OP_READ_SLOT, BAD_LIST, 16'h0000, 5'd0);
   endtask

   task automatic test_capacity_limits();
      wait_for_idle();
      write_capacity(CSR_CAP_A, 6'd0);
      write_capacity(CSR_CAP_B, 6'd2);
      write_capacity(CSR_CAP_C, 6'd63);
      write_capacity(CSR_UNUSED_INDEX, 6'd5);
      issue_request(OP_ADD, 2'd0, 16'h0011, 5'd0);
      issue_request(OP_ADD, 2'd1, 16'h0021, 5'd0);
      issue_request(OP_ADD, 2'd1, 16'h0022, 5'd0);
      issue_request(OP_ADD, 2'd1, 16'h0023, 5'd0);
      issue_request(OP_READ_SLOT, 2'd2, 16'h0000, 5'd31);
      // shrink list one, then grow it back so the hidden entry returns
      wait_for_idle();
      write_capacity(CSR_CAP_B, 6'd1);
      issue_request(OP_COUNT, 2'd1, 16'h0000, 5'd0);
      issue_request(OP_READ_SLOT, 2'd1, 16'h0000, 5'd1);
      wait_for_idle();
      write_capacity(CSR_CAP_B, 6'd2);
      issue_request(OP_COUNT, 2'd1, 16'h0000, 5'd0);
   endtask

   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned phase_len;
      int unsigned k;
      int unsigned l;
      int unsigned c;
      logic [SLOT_W-1:0] slot;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_for_idle();
         write_capacity(CSR_CAP_A, pick_capacity());
         write_capacity(CSR_CAP_B, pick_capacity());
         write_capacity(CSR_CAP_C, pick_capacity());
         if ($urandom_range(0, 3) == 0)
            write_capacity(CSR_UNUSED_INDEX, CAP_W'($urandom_range(0, 63)));
         for (k = 0; k < 6; k++) id_pool[k] = ID_W'($urandom);
         phase_len = $urandom_range(40, 110);
         if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
         for (k = 0; k < phase_len; k++) begin
            l = ($urandom_range(0, 15) == 0) ? BAD_LIST : $urandom_range(0, NUM_LISTS_DEF - 1);
            c = (l < NUM_LISTS_DEF) ? live_cap(l) : 0;
            if (c > 0 && $urandom_range(0, 1) == 1)
               slot = SLOT_W'($urandom_range(0, c - 1));
            else
               slot = SLOT_W'($urandom_range(0, 31));
            issue_request(pick_op(), LIST_SEL_W'(l), pick_id(), slot);
         end
         sent += phase_len;
      end
   endtask

   // result side: stall pattern and checking

   always @(posedge clock) begin
      stall_tick = stall_tick + 1;
      if (stall_tick % 150 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 2) != 0);
         2: rsp_bus.ready <= (stall_tick % 5 == 0);
         default: begin
            if (stall_hold == 0) begin
               ready_level = !ready_level;
               stall_hold  = ready_level ? $urandom_range(1, 6) : $urandom_range(1, 24);
            end else begin
               stall_hold--;
            end
            rsp_bus.ready <= ready_level;
         end
      endcase
   end

   always @(posedge clock) begin : check_answers
      list_answer_type want;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_answers.size() == 0) begin
            $error("result transfer with no request outstanding");
            fault_count++;
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_bus.ok !== want.ok) begin
               $error("ok expected %0d got %0d", want.ok, rsp_bus.ok);
               fault_count++;
            end
            if (rsp_bus.removed_count !== want.removed_count) begin
               $error("removed_count expected %0d got %0d", want.removed_count,
                      rsp_bus.removed_count);
               fault_count++;
            end
            if (rsp_bus.slot_value !== want.slot_value) begin
               $error("slot_value expected %0d got %0d", $signed(want.slot_value),
                      $signed(rsp_bus.slot_value));
               fault_count++;
            end
            if (rsp_bus.item_count !== want.item_count) begin
               $error("item_count expected %0d got %0d", want.item_count, rsp_bus.item_count);
               fault_count++;
            end
         end
      end
   end

   initial begin
      for (int l = 0; l < NUM_LISTS_DEF; l++) begin
         for (int s = 0; s < MAX_CAPACITY_DEF; s++) slot_mem[l][s] = EMPTY_ID;
      end
      for (int r = 0; r < NUM_CAP_REGS; r++) cap_shadow[r] = CAP_RESET;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_CAP_A;
      csr_write_data   <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.op       <= OP_COUNT;
      req_bus.list_sel <= '0;
      req_bus.item_id  <= '0;
      req_bus.slot     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_lists();
      test_add_and_search();
      test_removal();
      test_bad_list();
      test_capacity_limits();
      test_random_traffic();
      wait_for_idle();

      if (fault_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
